FILE: sv/bsrut_pkg.sv
// ----------------------------------------------------------------------------
// bsrut_pkg: shared types and constants
// Command codes, register indexes, widths and the control and status groups
// between the controller and the datapath of the triangular BSR engine.
// ----------------------------------------------------------------------------
package bsrut_pkg;

  localparam int unsigned MAX_BLOCK_DEF    = 8;
  localparam int unsigned VECTOR_DEPTH_DEF = 1024;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned IDX_W     = 10;
  localparam int unsigned BLK_W     = 10;
  localparam int unsigned POS_W     = 6;
  localparam int unsigned CMD_W     = 3;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned BSIZE_W   = 4;
  localparam int unsigned COUNT_W   = 11;
  localparam int unsigned ACC_W     = 64;
  localparam int unsigned OPND_W    = 33;
  localparam int unsigned PROD_W    = 2 * OPND_W;
  localparam int unsigned SUM_W     = 98;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned DIV_STEPS = POS_W;

  localparam logic [DATA_W-1:0]  ALPHA_RST  = 32'h0001_0000;
  localparam logic [DATA_W-1:0]  BETA_RST   = 32'h0000_0000;
  localparam logic [BSIZE_W-1:0] BSIZE_RST  = 4'd4;
  localparam logic [SUM_W-1:0]   ROUND_HALF = SUM_W'(32768);

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE_X = 3'd0,
    CMD_WRITE_Y = 3'd1,
    CMD_MATRIX  = 3'd2,
    CMD_READ    = 3'd3,
    CMD_CLEAR   = 3'd4
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA     = 3'd0,
    CFG_BETA      = 3'd1,
    CFG_BSIZE     = 3'd2,
    CFG_LAYOUT    = 3'd3,
    CFG_ROW_COUNT = 3'd4,
    CFG_COL_COUNT = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MUL_AX = 2'd0,  // matrix value times x
    MUL_BY = 2'd1,  // beta times y
    MUL_AL = 2'd2,  // alpha times low accumulator word
    MUL_AH = 2'd3   // alpha times high accumulator word
  } mul_sel_e;

  typedef struct packed {
    logic     capture;
    logic     wr_x;
    logic     wr_y;
    logic     div_step;
    logic     mat_read;
    logic     vec_read;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     add_en;
    logic     add_hi;
    logic     acc_update;
    logic     clr_step;
    logic     out_load;
  } dp_ctrl_t;

  typedef struct packed {
    logic clr_last;
  } dp_stat_t;

endpackage

FILE: sv/bsrut_ctrl.sv
// ----------------------------------------------------------------------------
// bsrut_ctrl: command sequencer
// One-hot state machine that steps the datapath through vector writes,
// matrix value updates, reads and the accumulator clearing sweep.
// ----------------------------------------------------------------------------
module bsrut_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [bsrut_pkg::CMD_W-1:0] cmd_i,
  input  bsrut_pkg::dp_stat_t        stat_i,
  output logic                       busy_o,
  output logic                       result_valid_o,
  output bsrut_pkg::dp_ctrl_t        ctrl_o
);

  localparam int unsigned DCW = $clog2(bsrut_pkg::DIV_STEPS);

  typedef enum logic [13:0] {
    S_CLEAR = 14'b00000000000001,
    S_IDLE  = 14'b00000000000010,
    S_DIV   = 14'b00000000000100,
    S_ADDR  = 14'b00000000001000,
    S_XMUL  = 14'b00000000010000,
    S_XADD  = 14'b00000000100000,
    S_XACC  = 14'b00000001000000,
    S_RBY   = 14'b00000010000000,
    S_RSY   = 14'b00000100000000,
    S_RAL   = 14'b00001000000000,
    S_RSL   = 14'b00010000000000,
    S_RAH   = 14'b00100000000000,
    S_RSH   = 14'b01000000000000,
    S_ROUT  = 14'b10000000000000
  } state_e;

  state_e         state_q, state_d;
  logic [DCW-1:0] div_cnt_q, div_cnt_d;
  logic           valid_q;
  logic           accept;

  assign busy_o         = (state_q != S_IDLE);
  assign accept         = start_i && (state_q == S_IDLE);
  assign result_valid_o = valid_q;

  always_comb begin
    state_d   = state_q;
    div_cnt_d = div_cnt_q;
    ctrl_o    = '0;
    ctrl_o.mul_sel = bsrut_pkg::MUL_AX;
    unique case (state_q)
      S_CLEAR: begin
        ctrl_o.clr_step = 1'b1;
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          ctrl_o.capture = 1'b1;
          unique case (bsrut_pkg::cmd_e'(cmd_i))
            bsrut_pkg::CMD_WRITE_X: ctrl_o.wr_x = 1'b1;
            bsrut_pkg::CMD_WRITE_Y: ctrl_o.wr_y = 1'b1;
            bsrut_pkg::CMD_MATRIX: begin
              div_cnt_d = '0;
              state_d   = S_DIV;
            end
            bsrut_pkg::CMD_READ: begin
              ctrl_o.vec_read = 1'b1;
              state_d         = S_RBY;
            end
            bsrut_pkg::CMD_CLEAR: state_d = S_CLEAR;
            default: ;
          endcase
        end
      end
      S_DIV: begin
        ctrl_o.div_step = 1'b1;
        div_cnt_d       = div_cnt_q + 1'b1;
        if (div_cnt_q == DCW'(bsrut_pkg::DIV_STEPS - 1)) begin
          state_d = S_ADDR;
        end
      end
      S_ADDR: begin
        ctrl_o.mat_read = 1'b1;
        state_d         = S_XMUL;
      end
      S_XMUL: begin
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.mul_sel = bsrut_pkg::MUL_AX;
        state_d        = S_XADD;
      end
      S_XADD: begin
        ctrl_o.add_en = 1'b1;
        state_d       = S_XACC;
      end
      S_XACC: begin
        ctrl_o.acc_update = 1'b1;
        state_d           = S_IDLE;
      end
      S_RBY: begin
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.mul_sel = bsrut_pkg::MUL_BY;
        state_d        = S_RSY;
      end
      S_RSY: begin
        ctrl_o.add_en = 1'b1;
        state_d       = S_RAL;
      end
      S_RAL: begin
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.mul_sel = bsrut_pkg::MUL_AL;
        state_d        = S_RSL;
      end
      S_RSL: begin
        ctrl_o.add_en = 1'b1;
        state_d       = S_RAH;
      end
      S_RAH: begin
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.mul_sel = bsrut_pkg::MUL_AH;
        state_d        = S_RSH;
      end
      S_RSH: begin
        ctrl_o.add_en = 1'b1;
        ctrl_o.add_hi = 1'b1;
        state_d       = S_ROUT;
      end
      S_ROUT: begin
        ctrl_o.out_load = 1'b1;
        state_d         = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      div_cnt_q <= '0;
      valid_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      div_cnt_q <= div_cnt_d;
      valid_q   <= (state_q == S_ROUT);
    end
  end

endmodule

FILE: sv/bsrut_dp.sv
// ----------------------------------------------------------------------------
// bsrut_dp: datapath
// Configuration registers, x, y and accumulator memories, the in-block
// position divider, one shared signed multiplier and a wide adder.
// ----------------------------------------------------------------------------
module bsrut_dp #(
  parameter int unsigned MAX_BLOCK    = bsrut_pkg::MAX_BLOCK_DEF,
  parameter int unsigned VECTOR_DEPTH = bsrut_pkg::VECTOR_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  bsrut_pkg::dp_ctrl_t               ctrl_i,
  output bsrut_pkg::dp_stat_t               stat_o,
  input  logic                              cfg_we_i,
  input  logic [bsrut_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [bsrut_pkg::CFG_W-1:0]       cfg_wdata_i,
  input  logic [bsrut_pkg::IDX_W-1:0]       vec_index_i,
  input  logic signed [bsrut_pkg::DATA_W-1:0] data_value_i,
  input  logic [bsrut_pkg::BLK_W-1:0]       block_row_i,
  input  logic [bsrut_pkg::BLK_W-1:0]       block_col_i,
  input  logic [bsrut_pkg::POS_W-1:0]       elem_pos_i,
  output logic signed [bsrut_pkg::DATA_W-1:0] result_value_o,
  output logic                              status_o,
  output logic                              saturated_o
);

  localparam int unsigned DW   = bsrut_pkg::DATA_W;
  localparam int unsigned AW   = $clog2(VECTOR_DEPTH);
  localparam int unsigned BSW  = $clog2(MAX_BLOCK + 1);
  localparam int unsigned IXW  = bsrut_pkg::BLK_W + BSW + 1;
  localparam int unsigned SQW  = 2 * BSW;
  localparam int unsigned CBW  = bsrut_pkg::COUNT_W + BSW;
  localparam int unsigned PW   = bsrut_pkg::POS_W;
  localparam int unsigned ACW  = bsrut_pkg::ACC_W;
  localparam int unsigned SW   = bsrut_pkg::SUM_W;
  localparam int unsigned PRW  = bsrut_pkg::PROD_W;
  localparam int unsigned FW   = bsrut_pkg::FRAC_W;
  localparam int unsigned SHW  = SW - FW;

  // configuration
  logic [DW-1:0]                     alpha_q, beta_q;
  logic [bsrut_pkg::BSIZE_W-1:0]     bsize_q;
  logic                              layout_q;
  logic [bsrut_pkg::COUNT_W-1:0]     rows_q, cols_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q  <= bsrut_pkg::ALPHA_RST;
      beta_q   <= bsrut_pkg::BETA_RST;
      bsize_q  <= bsrut_pkg::BSIZE_RST;
      layout_q <= 1'b0;
      rows_q   <= '0;
      cols_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (bsrut_pkg::cfg_idx_e'(cfg_index_i))
        bsrut_pkg::CFG_ALPHA:     alpha_q  <= cfg_wdata_i[DW-1:0];
        bsrut_pkg::CFG_BETA:      beta_q   <= cfg_wdata_i[DW-1:0];
        bsrut_pkg::CFG_BSIZE:     bsize_q  <= cfg_wdata_i[bsrut_pkg::BSIZE_W-1:0];
        bsrut_pkg::CFG_LAYOUT:    layout_q <= cfg_wdata_i[0];
        bsrut_pkg::CFG_ROW_COUNT: rows_q   <= cfg_wdata_i[bsrut_pkg::COUNT_W-1:0];
        bsrut_pkg::CFG_COL_COUNT: cols_q   <= cfg_wdata_i[bsrut_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // effective block edge: zero acts as one, clamp to the largest block
  logic [BSW-1:0] bs;
  always_comb begin
    priority if (bsize_q == '0) begin
      bs = BSW'(1);
    end else if (32'(bsize_q) > MAX_BLOCK) begin
      bs = BSW'(MAX_BLOCK);
    end else begin
      bs = BSW'(bsize_q);
    end
  end

  // captured item fields
  logic [DW-1:0]                 data_q;
  logic [bsrut_pkg::IDX_W-1:0]   idx_q;
  logic [bsrut_pkg::BLK_W-1:0]   brow_q, bcol_q;
  logic [PW-1:0]                 pos_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      data_q <= data_value_i;
      idx_q  <= vec_index_i;
      brow_q <= block_row_i;
      bcol_q <= block_col_i;
      pos_q  <= elem_pos_i;
    end
  end

  // restoring divider: position over block edge, one quotient bit per step
  logic [BSW-1:0] rem_q;
  logic [PW-1:0]  quot_q, dpos_q;
  logic [BSW:0]   trial, trial_sub;
  logic           trial_ge;

  assign trial     = {rem_q, dpos_q[PW-1]};
  assign trial_ge  = (trial >= {1'b0, bs});
  assign trial_sub = trial - {1'b0, bs};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      rem_q  <= '0;
      quot_q <= '0;
      dpos_q <= elem_pos_i;
    end else if (ctrl_i.div_step) begin
      dpos_q <= {dpos_q[PW-2:0], 1'b0};
      quot_q <= {quot_q[PW-2:0], trial_ge};
      rem_q  <= trial_ge ? trial_sub[BSW-1:0] : trial[BSW-1:0];
    end
  end

  // element coordinates and the kept test
  logic [PW-1:0]  row_in, col_in;
  logic [SQW-1:0] bs_sq;
  logic [IXW-1:0] xi, ai;
  logic [31:0]    xi_w, ai_w;
  logic           keep;

  assign row_in = layout_q ? PW'(rem_q) : quot_q;
  assign col_in = layout_q ? quot_q : PW'(rem_q);
  assign bs_sq  = SQW'(bs) * SQW'(bs);
  assign xi     = IXW'(brow_q) * IXW'(bs) + IXW'(row_in);
  assign ai     = IXW'(bcol_q) * IXW'(bs) + IXW'(col_in);
  assign xi_w   = 32'(xi);
  assign ai_w   = 32'(ai);

  assign keep = (bsrut_pkg::COUNT_W'(brow_q) < rows_q)
             && (bsrut_pkg::COUNT_W'(bcol_q) < cols_q)
             && (32'(pos_q) < 32'(bs_sq))
             && (bcol_q >= brow_q)
             && !((bcol_q == brow_q) && (col_in < row_in))
             && (xi_w < VECTOR_DEPTH)
             && (ai_w < VECTOR_DEPTH);

  logic          keep_q;
  logic [AW-1:0] ai_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_q <= 1'b0;
    end else if (ctrl_i.mat_read) begin
      keep_q <= keep;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mat_read) begin
      ai_q <= ai_w[AW-1:0];
    end
  end

  // vector index from the ports
  logic [31:0]   vidx_w;
  logic [AW-1:0] vaddr;
  logic          vidx_ok;

  assign vidx_w  = 32'(vec_index_i);
  assign vaddr   = vidx_w[AW-1:0];
  assign vidx_ok = (vidx_w < VECTOR_DEPTH);

  // clearing sweep over the accumulator
  logic [AW-1:0] clr_cnt_q;

  assign stat_o.clr_last = (clr_cnt_q == AW'(VECTOR_DEPTH - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (ctrl_i.clr_step) begin
      clr_cnt_q <= stat_o.clr_last ? '0 : clr_cnt_q + 1'b1;
    end
  end

  // memories
  logic [DW-1:0]  x_mem   [VECTOR_DEPTH];
  logic [DW-1:0]  y_mem   [VECTOR_DEPTH];
  logic [ACW-1:0] acc_mem [VECTOR_DEPTH];
  logic [DW-1:0]  x_rd_q, y_rd_q;
  logic [ACW-1:0] acc_rd_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_x && vidx_ok) begin
      x_mem[vaddr] <= data_value_i;
    end
    if (ctrl_i.mat_read) begin
      x_rd_q <= x_mem[xi_w[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_y && vidx_ok) begin
      y_mem[vaddr] <= data_value_i;
    end
    if (ctrl_i.vec_read) begin
      y_rd_q <= y_mem[vaddr];
    end
  end

  logic           acc_we, acc_re;
  logic [AW-1:0]  acc_waddr, acc_raddr;
  logic [ACW-1:0] acc_wdata, acc_new;

  assign acc_we    = ctrl_i.clr_step || (ctrl_i.acc_update && keep_q);
  assign acc_waddr = ctrl_i.clr_step ? clr_cnt_q : ai_q;
  assign acc_wdata = ctrl_i.clr_step ? '0 : acc_new;
  assign acc_re    = ctrl_i.mat_read || ctrl_i.vec_read;
  assign acc_raddr = ctrl_i.mat_read ? ai_w[AW-1:0] : vaddr;

  always_ff @(posedge clk_i) begin
    if (acc_we) begin
      acc_mem[acc_waddr] <= acc_wdata;
    end
    if (acc_re) begin
      acc_rd_q <= acc_mem[acc_raddr];
    end
  end

  // shared multiplier
  logic signed [bsrut_pkg::OPND_W-1:0] mul_a, mul_b;
  logic signed [PRW-1:0]               prod_q;

  always_comb begin
    mul_a = {data_q[DW-1], data_q};
    mul_b = {x_rd_q[DW-1], x_rd_q};
    unique case (ctrl_i.mul_sel)
      bsrut_pkg::MUL_AX: begin
        mul_a = {data_q[DW-1], data_q};
        mul_b = {x_rd_q[DW-1], x_rd_q};
      end
      bsrut_pkg::MUL_BY: begin
        mul_a = {beta_q[DW-1], beta_q};
        mul_b = {y_rd_q[DW-1], y_rd_q};
      end
      bsrut_pkg::MUL_AL: begin
        mul_a = {alpha_q[DW-1], alpha_q};
        mul_b = {1'b0, acc_rd_q[DW-1:0]};
      end
      bsrut_pkg::MUL_AH: begin
        mul_a = {alpha_q[DW-1], alpha_q};
        mul_b = {acc_rd_q[ACW-1], acc_rd_q[ACW-1:DW]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= mul_a * mul_b;
    end
  end

  // running sum, seeded with the rounding half
  logic [SW-1:0] sum_q, addend;

  always_comb begin
    addend = {{(SW - PRW){prod_q[PRW-1]}}, prod_q};
    if (ctrl_i.add_hi) begin
      addend = addend << DW;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      sum_q <= bsrut_pkg::ROUND_HALF;
    end else if (ctrl_i.add_en) begin
      sum_q <= sum_q + addend;
    end
  end

  // accumulator update with saturation at the 64-bit limits
  logic [ACW:0] rnd_ext, acc_ext, acc_tot;

  assign rnd_ext = sum_q[ACW+FW:FW];
  assign acc_ext = {acc_rd_q[ACW-1], acc_rd_q};
  assign acc_tot = acc_ext + rnd_ext;

  always_comb begin
    if (acc_tot[ACW] != acc_tot[ACW-1]) begin
      acc_new = acc_tot[ACW] ? {1'b1, {(ACW-1){1'b0}}} : {1'b0, {(ACW-1){1'b1}}};
    end else begin
      acc_new = acc_tot[ACW-1:0];
    end
  end

  // read result
  logic [SHW-1:0]     shifted;
  logic               fits, neg;
  logic [CBW-1:0]     cols_bs;
  logic               idx_ok, beyond, non_square;

  assign shifted    = sum_q[SW-1:FW];
  assign neg        = sum_q[SW-1];
  assign fits       = (&shifted[SHW-1:DW-1]) || !(|shifted[SHW-1:DW-1]);
  assign cols_bs    = CBW'(cols_q) * CBW'(bs);
  assign idx_ok     = (32'(idx_q) < VECTOR_DEPTH);
  assign beyond     = (32'(idx_q) >= 32'(cols_bs));
  assign non_square = (rows_q != cols_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      status_o    <= 1'b0;
      saturated_o <= 1'b0;
      priority if (!idx_ok) begin
        result_value_o <= '0;
      end else if (non_square) begin
        result_value_o <= y_rd_q;
        status_o       <= 1'b1;
      end else if (beyond) begin
        result_value_o <= y_rd_q;
      end else if (fits) begin
        result_value_o <= shifted[DW-1:0];
      end else begin
        result_value_o <= neg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        saturated_o    <= 1'b1;
      end
    end
  end

endmodule

FILE: sv/bsr_upper_triangular_transposed_mv_top.sv
// ----------------------------------------------------------------------------
// bsr_upper_triangular_transposed_mv_top: transposed upper-triangular BSR MV
// Computes y = beta*y + alpha*transpose(upper(A))*x in Q16.16, one element
// per read command, from x, y and block values written one beat at a time.
// ----------------------------------------------------------------------------
// Usage: a command is taken on a clock edge with start high and busy low.
// Writes of x and y finish on that edge and keep busy low. A matrix value
// holds busy through the bit-serial split of the in-block position into row
// and column, then address, multiply, round and accumulate. A read holds
// busy for three passes through the one shared multiplier, and its result
// is on the ports with result_valid_o high for exactly one cycle, the one
// in which busy falls again; it is taken on the edge that ends that cycle
// and there is no way to stall it, so sample it then. Reset and the clear
// command sweep the accumulator memory one entry per cycle with busy high.
// Configuration writes are taken on any edge and belong in idle time.
// ----------------------------------------------------------------------------
module bsr_upper_triangular_transposed_mv_top #(
  parameter int unsigned MAX_BLOCK    = bsrut_pkg::MAX_BLOCK_DEF,
  parameter int unsigned VECTOR_DEPTH = bsrut_pkg::VECTOR_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [bsrut_pkg::CMD_W-1:0]         cmd_i,
  input  logic [bsrut_pkg::IDX_W-1:0]         vec_index_i,
  input  logic signed [bsrut_pkg::DATA_W-1:0] data_value_i,
  input  logic [bsrut_pkg::BLK_W-1:0]         block_row_i,
  input  logic [bsrut_pkg::BLK_W-1:0]         block_col_i,
  input  logic [bsrut_pkg::POS_W-1:0]         elem_pos_i,
  input  logic                                cfg_we_i,
  input  logic [bsrut_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [bsrut_pkg::CFG_W-1:0]         cfg_wdata_i,
  output logic                                result_valid_o,
  output logic signed [bsrut_pkg::DATA_W-1:0] result_value_o,
  output logic                                status_o,
  output logic                                saturated_o
);

  bsrut_pkg::dp_ctrl_t dp_ctrl;
  bsrut_pkg::dp_stat_t dp_stat;

  bsrut_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .cmd_i          (cmd_i),
    .stat_i         (dp_stat),
    .busy_o         (busy),
    .result_valid_o (result_valid_o),
    .ctrl_o         (dp_ctrl)
  );

  bsrut_dp #(
    .MAX_BLOCK    (MAX_BLOCK),
    .VECTOR_DEPTH (VECTOR_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (dp_ctrl),
    .stat_o         (dp_stat),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .vec_index_i    (vec_index_i),
    .data_value_i   (data_value_i),
    .block_row_i    (block_row_i),
    .block_col_i    (block_col_i),
    .elem_pos_i     (elem_pos_i),
    .result_value_o (result_value_o),
    .status_o       (status_o),
    .saturated_o    (saturated_o)
  );

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the transposed upper-triangular BSR engine
// Loads x and y, streams block values in well-formed and broken sequences,
// issues reads and checks every read beat against an untimed model of the
// engine kept in a small tracker class, over several register settings.
// ----------------------------------------------------------------------------
module tb_top;
  import bsrut_pkg::*;

  localparam int unsigned DEPTH       = VECTOR_DEPTH_DEF;
  localparam int unsigned PHASES      = 9;
  localparam int unsigned PHASE_BEATS = 140;
  localparam int unsigned IDLE_PCT    = 30;
  localparam int unsigned SETTLE      = 12;
  localparam int unsigned CYCLE_LIMIT = 400000;

  localparam logic [DATA_W-1:0] Q_ONE     = 32'h0001_0000;
  localparam logic [DATA_W-1:0] Q_HALF    = 32'h0000_8000;
  localparam logic [DATA_W-1:0] Q_NEG_ONE = 32'hffff_0000;
  localparam logic [DATA_W-1:0] Q_MAX     = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] Q_MIN     = 32'h8000_0000;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic                     status;
    logic                     clipped;
  } read_beat_t;

  class spmv_tracker;
    logic signed [DATA_W-1:0] x_mem [DEPTH];
    logic signed [DATA_W-1:0] y_mem [DEPTH];
    logic signed [ACC_W-1:0]  acc_mem [DEPTH];
    logic signed [DATA_W-1:0] alpha;
    logic signed [DATA_W-1:0] beta;
    logic [BSIZE_W-1:0]       bsize;
    logic                     layout;
    logic [COUNT_W-1:0]       rows;
    logic [COUNT_W-1:0]       cols;
    read_beat_t               due_reads [$];
    int unsigned              mismatches;

    function new();
      alpha = ALPHA_RST;
      beta = BETA_RST;
      bsize = BSIZE_RST;
      layout = 1'b0;
      rows = '0;
      cols = '0;
      mismatches = 0;
      foreach (acc_mem[i]) acc_mem[i] = '0;
    endfunction

    function int unsigned eff_bs();
      if (bsize == 0) return 1;
      if (bsize > MAX_BLOCK_DEF) return MAX_BLOCK_DEF;
      return bsize;
    endfunction

    function void set_reg(cfg_idx_e which, logic [CFG_W-1:0] v);
      case (which)
        CFG_ALPHA:     alpha = v;
        CFG_BETA:      beta = v;
        CFG_BSIZE:     bsize = v[BSIZE_W-1:0];
        CFG_LAYOUT:    layout = v[0];
        CFG_ROW_COUNT: rows = v[COUNT_W-1:0];
        CFG_COL_COUNT: cols = v[COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    // x index a block value multiplies, or -1 when the value is dropped
    function int map_value(int unsigned brow, int unsigned bcol, int unsigned pos,
                           output int acc_idx);
      int unsigned bs, r, c, xi, ai;
      bs = eff_bs();
      acc_idx = -1;
      if (brow >= rows || bcol >= cols || pos >= bs * bs) return -1;
      if (layout) begin
        c = pos / bs;
        r = pos % bs;
      end else begin
        r = pos / bs;
        c = pos % bs;
      end
      if (bcol < brow || (bcol == brow && c < r)) return -1;
      xi = brow * bs + r;
      ai = bcol * bs + c;
      if (xi >= DEPTH || ai >= DEPTH) return -1;
      acc_idx = ai;
      return xi;
    endfunction

    function void apply_command(logic [CMD_W-1:0] op, logic [IDX_W-1:0] idx,
                                logic signed [DATA_W-1:0] data, logic [BLK_W-1:0] brow,
                                logic [BLK_W-1:0] bcol, logic [POS_W-1:0] pos);
      int                 xi, ai;
      logic signed [63:0] dv, xv, prod;
      logic signed [ACC_W:0] acc_sum;
      logic signed [99:0] ga, gb, yv, av, total;
      read_beat_t         beat;
      case (op)
        CMD_WRITE_X: x_mem[idx] = data;
        CMD_WRITE_Y: y_mem[idx] = data;
        CMD_MATRIX: begin
          xi = map_value(brow, bcol, pos, ai);
          if (xi >= 0) begin
            dv = data;
            xv = x_mem[xi];
            // round half up to Q16.16, then add with 64-bit clipping
            prod = (dv * xv + 64'sd32768) >>> 16;
            acc_sum = acc_mem[ai] + prod;
            if (acc_sum[ACC_W] != acc_sum[ACC_W-1])
              acc_mem[ai] = acc_sum[ACC_W] ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
            else
              acc_mem[ai] = acc_sum[ACC_W-1:0];
          end
        end
        CMD_READ: begin
          beat.value = y_mem[idx];
          beat.status = 1'b0;
          beat.clipped = 1'b0;
          if (rows != cols) begin
            beat.status = 1'b1;
          end else if (idx < cols * eff_bs()) begin
            ga = alpha;
            gb = beta;
            yv = y_mem[idx];
            av = acc_mem[idx];
            total = (gb * yv + ga * av + 100'sd32768) >>> 16;
            if (total > 100'sd2147483647) begin
              beat.value = Q_MAX;
              beat.clipped = 1'b1;
            end else if (total < -100'sd2147483648) begin
              beat.value = Q_MIN;
              beat.clipped = 1'b1;
            end else begin
              beat.value = total[DATA_W-1:0];
            end
          end
          due_reads.push_back(beat);
        end
        CMD_CLEAR: foreach (acc_mem[i]) acc_mem[i] = '0;
        default: ;
      endcase
    endfunction

    function void compare_read(logic signed [DATA_W-1:0] value, logic status, logic clipped);
      read_beat_t want;
      if (due_reads.size() == 0) begin
        $display("%0t: read beat with none due: value %h status %b saturated %b",
                 $time, value, status, clipped);
        mismatches++;
        return;
      end
      want = due_reads.pop_front();
      if (value !== want.value) begin
        $display("%0t: result_value expected %h, actual %h", $time, want.value, value);
        mismatches++;
      end
      if (status !== want.status) begin
        $display("%0t: status expected %b, actual %b", $time, want.status, status);
        mismatches++;
      end
      if (clipped !== want.clipped) begin
        $display("%0t: saturated expected %b, actual %b", $time, want.clipped, clipped);
        mismatches++;
      end
    endfunction
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [CMD_W-1:0]         cmd_i = '0;
  logic [IDX_W-1:0]         vec_index_i = '0;
  logic signed [DATA_W-1:0] data_value_i = '0;
  logic [BLK_W-1:0]         block_row_i = '0;
  logic [BLK_W-1:0]         block_col_i = '0;
  logic [POS_W-1:0]         elem_pos_i = '0;
  logic                     cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index_i = '0;
  logic [CFG_W-1:0]         cfg_wdata_i = '0;
  logic                     result_valid_o;
  logic signed [DATA_W-1:0] result_value_o;
  logic                     status_o;
  logic                     saturated_o;

  spmv_tracker sb = new();
  bit          x_known [DEPTH];
  bit          y_known [DEPTH];
  int unsigned cycle_count = 0;

  bsr_upper_triangular_transposed_mv_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .vec_index_i    (vec_index_i),
    .data_value_i   (data_value_i),
    .block_row_i    (block_row_i),
    .block_col_i    (block_col_i),
    .elem_pos_i     (elem_pos_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .result_value_o (result_value_o),
    .status_o       (status_o),
    .saturated_o    (saturated_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // everything is sampled on the edge that takes it
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) sb.compare_read(result_value_o, status_o, saturated_o);
      if (cfg_we_i) sb.set_reg(cfg_idx_e'(cfg_index_i), cfg_wdata_i);
      if (start && !busy)
        sb.apply_command(cmd_i, vec_index_i, data_value_i, block_row_i, block_col_i,
                         elem_pos_i);
    end
  end

  function automatic logic [DATA_W-1:0] rand_q();
    case ($urandom_range(11))
      0:       return Q_MAX;
      1:       return Q_MIN;
      2:       return Q_ONE;
      3:       return Q_NEG_ONE;
      4:       return '0;
      5, 6, 7: return DATA_W'($urandom_range(524287)) - 32'd262144;
      default: return $urandom();
    endcase
  endfunction

  task automatic program_regs(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b,
                              logic [BSIZE_W-1:0] bs, logic lay,
                              logic [COUNT_W-1:0] nrows, logic [COUNT_W-1:0] ncols);
    cfg_idx_e         order [6];
    logic [CFG_W-1:0] vals [6];
    order = '{CFG_ALPHA, CFG_BETA, CFG_BSIZE, CFG_LAYOUT, CFG_ROW_COUNT, CFG_COL_COUNT};
    // junk above each register's width must be ignored
    foreach (vals[i]) vals[i] = $urandom();
    vals[0] = a;
    vals[1] = b;
    vals[2][BSIZE_W-1:0] = bs;
    vals[3][0] = lay;
    vals[4][COUNT_W-1:0] = nrows;
    vals[5][COUNT_W-1:0] = ncols;
    foreach (order[i]) begin
      cfg_we_i <= 1'b1;
      cfg_index_i <= order[i];
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_quiet();
    start <= 1'b0;
    // give a just-taken command time to raise busy
    repeat (2) @(posedge clk_i);
    while (busy || sb.due_reads.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic drive_beat(logic [CMD_W-1:0] op, int unsigned idx, logic [DATA_W-1:0] data,
                            int unsigned brow, int unsigned bcol, int unsigned pos,
                            int unsigned idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(12, 1)) @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= op;
    vec_index_i <= IDX_W'(idx);
    data_value_i <= data;
    block_row_i <= BLK_W'(brow);
    block_col_i <= BLK_W'(bcol);
    elem_pos_i <= POS_W'(pos);
    do @(posedge clk_i); while (busy);
    if (op == CMD_WRITE_X) x_known[idx] = 1'b1;
    else if (op == CMD_WRITE_Y) y_known[idx] = 1'b1;
  endtask

  // write first any x or y entry the command would read
  task automatic send_beat(logic [CMD_W-1:0] op, int unsigned idx, logic [DATA_W-1:0] data,
                           int unsigned brow, int unsigned bcol, int unsigned pos,
                           int unsigned idle_pct);
    int xi, ai;
    if (op == CMD_MATRIX) begin
      xi = sb.map_value(brow, bcol, pos, ai);
      if (xi >= 0 && !x_known[xi])
        drive_beat(CMD_WRITE_X, xi, rand_q(), brow, bcol, pos, idle_pct);
    end else if (op == CMD_READ && !y_known[idx]) begin
      drive_beat(CMD_WRITE_Y, idx, rand_q(), brow, bcol, pos, idle_pct);
    end
    drive_beat(op, idx, data, brow, bcol, pos, idle_pct);
  endtask

  task automatic random_beat(int unsigned idle_pct);
    int unsigned      roll, bs, span, rlim, clim, xlim, lim, brow, bcol, pos, idx;
    logic [CMD_W-1:0] op;
    bs = sb.eff_bs();
    span = (DEPTH + bs - 1) / bs;
    rlim = (sb.rows > DEPTH) ? DEPTH : sb.rows;
    clim = (sb.cols > DEPTH) ? DEPTH : sb.cols;
    // half the time keep blocks where they still land inside the vectors
    if ($urandom_range(1)) begin
      rlim = (rlim > span) ? span : rlim;
      clim = (clim > span) ? span : clim;
    end
    xlim = (rlim * bs > DEPTH) ? DEPTH : rlim * bs;
    lim = (sb.cols * bs > DEPTH) ? DEPTH : sb.cols * bs;
    brow = $urandom_range(DEPTH - 1);
    bcol = $urandom_range(DEPTH - 1);
    pos = $urandom_range((1 << POS_W) - 1);
    idx = $urandom_range(DEPTH - 1);
    roll = $urandom_range(999);
    op = CMD_MATRIX;
    if (roll < 120) begin
      op = CMD_WRITE_X;
      if (roll < 60 && xlim != 0) idx = $urandom_range(xlim - 1);
    end else if (roll < 200) begin
      op = CMD_WRITE_Y;
    end else if (roll < 700) begin
      if (rlim != 0 && clim != 0) begin
        brow = $urandom_range(rlim - 1);
        if (brow < clim && $urandom_range(9) < 7) bcol = $urandom_range(clim - 1, brow);
        else bcol = $urandom_range(clim - 1);
        pos = $urandom_range(bs * bs - 1);
      end
    end else if (roll < 760) begin
      op = CMD_MATRIX;  // fully random fields
    end else if (roll < 960) begin
      op = CMD_READ;
      if (lim != 0 && $urandom_range(99) < 85) idx = $urandom_range(lim - 1);
    end else if (roll < 967) begin
      op = CMD_CLEAR;
    end else begin
      op = CMD_W'($urandom_range((1 << CMD_W) - 1, int'(CMD_CLEAR) + 1));
    end
    send_beat(op, idx, rand_q(), brow, bcol, pos, idle_pct);
  endtask

  initial begin
    logic [COUNT_W-1:0] side;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait_quiet();

    // directed: 2x2 blocks, 2x2 block grid, row-major
    program_regs(Q_ONE, Q_HALF, 4'd2, 1'b0, 11'd2, 11'd2);
    send_beat(CMD_WRITE_X, 0, Q_MAX, 0, 0, 0, 0);
    send_beat(CMD_WRITE_X, 1, Q_MIN, 0, 0, 0, 0);
    send_beat(CMD_WRITE_X, 2, Q_ONE, 0, 0, 0, 0);
    send_beat(CMD_WRITE_X, 3, Q_NEG_ONE, 0, 0, 0, 0);
    send_beat(CMD_WRITE_Y, 0, Q_MAX, 0, 0, 0, 0);
    send_beat(CMD_WRITE_Y, 1, Q_MIN, 0, 0, 0, 0);
    send_beat(CMD_WRITE_Y, 2, 32'h0001_8000, 0, 0, 0, 0);
    send_beat(CMD_WRITE_Y, 3, '0, 0, 0, 0, 0);
    send_beat(CMD_MATRIX, 0, Q_MAX, 0, 0, 0, 0);
    send_beat(CMD_MATRIX, 0, Q_MIN, 0, 0, 1, 0);
    // below the diagonal of a diagonal block: dropped
    send_beat(CMD_MATRIX, 0, Q_ONE, 0, 0, 2, 0);
    send_beat(CMD_MATRIX, 0, 32'h0002_0000, 0, 0, 3, 0);
    // block left of the diagonal: dropped
    send_beat(CMD_MATRIX, 0, Q_ONE, 1, 0, 0, 0);
    send_beat(CMD_MATRIX, 0, Q_NEG_ONE, 0, 1, 3, 0);
    // position outside the block, then block outside the matrix
    send_beat(CMD_MATRIX, 0, Q_ONE, 0, 0, (1 << POS_W) - 1, 0);
    send_beat(CMD_MATRIX, 0, Q_ONE, DEPTH - 1, DEPTH - 1, 0, 0);
    for (int i = 0; i < 4; i++) send_beat(CMD_READ, i, '0, 0, 0, 0, 0);
    // read beyond the matrix answers y as written
    send_beat(CMD_READ, DEPTH - 1, '0, 0, 0, 0, 0);
    send_beat(CMD_W'(int'(CMD_CLEAR) + 1), 0, Q_ONE, 0, 0, 0, 0);
    send_beat(CMD_W'((1 << CMD_W) - 1), 0, Q_ONE, 0, 0, 0, 0);
    send_beat(CMD_CLEAR, 0, '0, 0, 0, 0, 0);
    send_beat(CMD_READ, 1, '0, 0, 0, 0, 0);

    for (int p = 0; p < PHASES; p++) begin
      wait_quiet();
      case (p)
        0: program_regs(Q_ONE, '0, 4'd4, 1'b0, 11'd4, 11'd4);
        1: program_regs(Q_MAX, Q_MIN, 4'd1, 1'b1, 11'd16, 11'd16);
        2: program_regs(Q_NEG_ONE, Q_ONE, 4'd8, 1'b1, 11'd3, 11'd3);
        // non-square: reads answer y with status set
        3: program_regs(rand_q(), rand_q(), 4'd3, 1'b0, 11'd5, 11'd4);
        // block size zero acts as one; empty matrix
        4: program_regs('0, Q_MAX, 4'd0, 1'b1, 11'd0, 11'd0);
        // oversize blocks clip to the maximum; indexes run past the vectors
        5: program_regs(Q_MIN, Q_MAX, 4'd15, 1'b0, 11'd1024, 11'd1024);
        6: program_regs(Q_HALF, 32'hffff_8000, 4'd5, 1'b1, 11'd2047, 11'd2047);
        default: begin
          side = COUNT_W'($urandom_range(6, 1));
          program_regs(rand_q(), rand_q(), BSIZE_W'($urandom_range(8, 1)),
                       1'($urandom_range(1)), side,
                       ($urandom_range(3) == 0) ? side + 1'b1 : side);
        end
      endcase
      // one phase runs with no idling at all
      for (int n = 0; n < PHASE_BEATS; n++) random_beat((p == 2) ? 0 : IDLE_PCT);
    end

    wait_quiet();
    if (sb.mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: files.f
sv/bsrut_pkg.sv
sv/bsrut_ctrl.sv
sv/bsrut_dp.sv
sv/bsr_upper_triangular_transposed_mv_top.sv
test/tb_top.sv
